// File: design/fpi_pkg.sv
package fpi_pkg;

  localparam int ERROR_TERMS    = 8;
  localparam int RATE_TERMS     = 8;
  localparam int OUTPUT_TERMS   = 8;
  localparam int MAX_CONDITIONS = 8;

  // point store: error points, rate points, then output centers
  localparam int PMEM_DEPTH = 72;
  localparam int PMEM_AW    = $clog2(PMEM_DEPTH);
  localparam int RMEM_DEPTH = 64;
  localparam int RMEM_AW    = $clog2(RMEM_DEPTH);

  localparam logic [15:0] DEG_ONE = 16'h8000;

  typedef enum logic [2:0] {
    KIND_EVAL    = 3'd0,
    KIND_ERR_PT  = 3'd1,
    KIND_RATE_PT = 3'd2,
    KIND_CENTER  = 3'd3,
    KIND_RULE    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DEG,
    ST_DIV_DEG,
    ST_RULE,
    ST_ACC,
    ST_DIV_OUT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         entry_index;
    logic signed [15:0] entry_value;
    logic signed [15:0] error_sample;
    logic signed [15:0] rate_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               no_rule_fired;
  } out_word_t;

endpackage

// File: design/fpi_ram.sv
module fpi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/fuzzy_pd_inference.sv
// Fuzzy PD controller: error and rate samples in, Q8.8 drive out.
// Input channel (in_valid_i / in_stall_o) carries one word per item. Write
// kinds load term points, centers or rule conditions; they give no result.
// An evaluate word gives one result word on the output channel
// (out_valid_o / out_stall_i).
// Evaluate sequence: each of the 16 terms fetches its four points and is
// classified, then runs the divider when the sample sits on a slope
// (one quotient bit per cycle). Then the 64 rule slots are walked, the
// centers are weighted, the weighted sum is divided one quotient bit per
// cycle (skipped when no rule fires), and the output register is loaded.
// The time per evaluate is set by the shared bit-serial divider and the
// single read port of the point memory.
// One item is in work at a time; in_stall_o is high until it finishes.
// A finished word waits in the output register; the next item is taken
// while it waits, and a second evaluate holds at its end until it drains.
// Reset clears all rule conditions (rules unused) and no_rule_value.
// Points and centers are undefined until written.
// APB register 0 (address 0): no_rule_value, the fallback drive.
module fuzzy_pd_inference (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fpi_pkg::in_word_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fpi_pkg::out_word_t out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  fpi_pkg::state_e state_q, state_d;

  logic               in_acc;
  logic               out_free;
  logic signed [15:0] nrv_q;

  logic [3:0]         term_q, term_d;
  logic [6:0]         cnt_q, cnt_d;
  logic signed [15:0] pt_q [4];
  logic signed [15:0] xe_q, xr_q;
  logic [15:0]        edeg_q [8];
  logic [15:0]        rdeg_q [8];
  logic [15:0]        warr_q [8];
  logic [15:0]        w_q, w_d;
  logic [18:0]        dacc_q, dacc_d;
  logic signed [35:0] num_q, num_d;
  logic signed [32:0] prod_q, prod_d;
  logic               pv_q, pv_d;
  logic [18:0]        rem_q, rem_d;
  logic [35:0]        dq_q, dq_d;
  logic [18:0]        den_q, den_d;
  logic               neg_q, neg_d;
  logic               fb_q, fb_d;

  logic [63:0]        rvld_q;
  logic               rv_q;

  logic               out_valid_q;
  fpi_pkg::out_word_t out_q;
  fpi_pkg::out_word_t res;

  // memory ports
  logic                        pm_we;
  logic [fpi_pkg::PMEM_AW-1:0] pm_waddr, pm_raddr;
  logic [15:0]                 pm_rdata;
  logic                        rm_we;
  logic [fpi_pkg::RMEM_AW-1:0] rm_raddr;
  logic [6:0]                  rm_rdata;

  // degree and strength writes
  logic        deg_we;
  logic [15:0] deg_val;
  logic        w_we;
  logic [2:0]  w_idx;
  logic [15:0] w_val;

  assign in_stall_o = (state_q != fpi_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) begin
      prdata = {{16{nrv_q[15]}}, nrv_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrv_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      nrv_q <= pwdata[15:0];
    end
  end

  // writes into the point store and rule store
  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = '0;
    rm_we    = 1'b0;
    if (in_acc) begin
      case (fpi_pkg::kind_e'(in_i.kind))
        fpi_pkg::KIND_ERR_PT: begin
          pm_we    = !in_i.entry_index[5];
          pm_waddr = {2'b00, in_i.entry_index[4:0]};
        end
        fpi_pkg::KIND_RATE_PT: begin
          pm_we    = !in_i.entry_index[5];
          pm_waddr = {2'b01, in_i.entry_index[4:0]};
        end
        fpi_pkg::KIND_CENTER: begin
          pm_we    = (in_i.entry_index[5:3] == 3'd0);
          pm_waddr = {4'b1000, in_i.entry_index[2:0]};
        end
        fpi_pkg::KIND_RULE: begin
          rm_we = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  fpi_ram #(.WIDTH(16), .DEPTH(fpi_pkg::PMEM_DEPTH)) u_pmem (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (in_i.entry_value),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  fpi_ram #(.WIDTH(7), .DEPTH(fpi_pkg::RMEM_DEPTH)) u_rmem (
    .clk_i   (clk_i),
    .we_i    (rm_we),
    .waddr_i (in_i.entry_index),
    .wdata_i (in_i.entry_value[6:0]),
    .raddr_i (rm_raddr),
    .rdata_o (rm_rdata)
  );

  // trapezoid classification of the current term
  logic signed [15:0] x, pa, pb, pc, pd;
  logic               tz_zero, tz_one, tz_rise, need_div;
  logic signed [16:0] diff_rise, diff_fall, span_rise, span_fall;

  always_comb begin
    x  = term_q[3] ? xr_q : xe_q;
    pa = pt_q[0];
    pb = pt_q[1];
    pc = pt_q[2];
    pd = pt_q[3];
    tz_zero   = (x < pa) || (x > pd);
    tz_one    = (x == pb && pa == pb) || (x == pd && pc == pd) || (x >= pb && x <= pc);
    tz_rise   = (x < pb);
    need_div  = !tz_zero && !tz_one;
    diff_rise = 17'(x) - 17'(pa);
    diff_fall = 17'(pd) - 17'(x);
    span_rise = 17'(pb) - 17'(pa);
    span_fall = 17'(pd) - 17'(pc);
  end

  // shared restoring divider step
  logic [19:0] rem_sh;
  logic        div_ge;
  logic [19:0] rem_sub;
  always_comb begin
    rem_sh  = {rem_q, dq_q[35]};
    div_ge  = (rem_sh >= {1'b0, den_q});
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // rule slot being processed
  logic [5:0]  rslot;
  logic [6:0]  rr;
  logic [15:0] de, dr, m, wcur, wnext;
  logic        used;
  always_comb begin
    rslot = 6'(cnt_q - 7'd1);
    rr    = rv_q ? rm_rdata : 7'd0;
    de    = ({1'b0, rr[5:3]} < 4'(fpi_pkg::ERROR_TERMS)) ? edeg_q[rr[5:3]] : 16'd0;
    dr    = ({1'b0, rr[2:0]} < 4'(fpi_pkg::RATE_TERMS)) ? rdeg_q[rr[2:0]] : 16'd0;
    m     = (de < dr) ? de : dr;
    used  = rr[6] && ({1'b0, rslot[2:0]} < 4'(fpi_pkg::MAX_CONDITIONS));
    wcur  = (rslot[2:0] == 3'd0) ? 16'd0 : w_q;
    wnext = (used && m > wcur) ? m : wcur;
  end

  // magnitude with rounding, fallback and saturation
  logic [35:0] mag;
  always_comb begin
    mag = num_q[35] ? 36'(-num_q) : 36'(num_q);
    mag = mag + {17'd0, dacc_q[18:1]};
    res = '0;
    if (fb_q) begin
      res.drive         = nrv_q;
      res.no_rule_fired = 1'b1;
    end else if (!neg_q) begin
      res.drive = (dq_q > 36'd32767) ? 16'sh7FFF : dq_q[15:0];
    end else begin
      res.drive = (dq_q > 36'd32768) ? 16'sh8000 : 16'(-dq_q[15:0]);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fpi_pkg::ST_IDLE: begin
        if (in_acc && fpi_pkg::kind_e'(in_i.kind) == fpi_pkg::KIND_EVAL) begin
          state_d = fpi_pkg::ST_LOAD;
        end
      end
      fpi_pkg::ST_LOAD: begin
        if (cnt_q == 7'd4) state_d = fpi_pkg::ST_DEG;
      end
      fpi_pkg::ST_DEG: begin
        if (need_div) state_d = fpi_pkg::ST_DIV_DEG;
        else if (term_q == 4'd15) state_d = fpi_pkg::ST_RULE;
        else state_d = fpi_pkg::ST_LOAD;
      end
      fpi_pkg::ST_DIV_DEG: begin
        if (cnt_q == 7'd14) begin
          state_d = (term_q == 4'd15) ? fpi_pkg::ST_RULE : fpi_pkg::ST_LOAD;
        end
      end
      fpi_pkg::ST_RULE: begin
        if (cnt_q == 7'd64) state_d = fpi_pkg::ST_ACC;
      end
      fpi_pkg::ST_ACC: begin
        if (cnt_q == 7'd10) begin
          state_d = (dacc_q == '0) ? fpi_pkg::ST_DONE : fpi_pkg::ST_DIV_OUT;
        end
      end
      fpi_pkg::ST_DIV_OUT: begin
        if (cnt_q == 7'd35) state_d = fpi_pkg::ST_DONE;
      end
      fpi_pkg::ST_DONE: begin
        if (out_free) state_d = fpi_pkg::ST_IDLE;
      end
      default: state_d = fpi_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    term_d   = term_q;
    cnt_d    = cnt_q + 7'd1;
    w_d      = w_q;
    dacc_d   = dacc_q;
    num_d    = num_q;
    prod_d   = prod_q;
    pv_d     = 1'b0;
    rem_d    = rem_q;
    dq_d     = dq_q;
    den_d    = den_q;
    neg_d    = neg_q;
    fb_d     = fb_q;
    pm_raddr = {1'b0, term_q[3], term_q[2:0], cnt_q[1:0]};
    rm_raddr = cnt_q[5:0];
    deg_we   = 1'b0;
    deg_val  = '0;
    w_we     = 1'b0;
    w_idx    = rslot[5:3];
    w_val    = '0;
    case (state_q)
      fpi_pkg::ST_IDLE: begin
        term_d = '0;
        cnt_d  = '0;
        dacc_d = '0;
        num_d  = '0;
        fb_d   = 1'b0;
      end
      fpi_pkg::ST_LOAD: begin
        if (cnt_q == 7'd4) cnt_d = '0;
      end
      fpi_pkg::ST_DEG: begin
        cnt_d = '0;
        rem_d = tz_rise ? {3'd0, diff_rise[15:0]} : {3'd0, diff_fall[15:0]};
        den_d = tz_rise ? {3'd0, span_rise[15:0]} : {3'd0, span_fall[15:0]};
        dq_d  = '0;
        if (!need_div) begin
          deg_we  = 1'b1;
          // outside the support wins over any plateau test
          deg_val = (tz_one && !tz_zero) ? fpi_pkg::DEG_ONE : 16'd0;
          term_d  = term_q + 4'd1;
        end
      end
      fpi_pkg::ST_DIV_DEG: begin
        rem_d = div_ge ? rem_sub[18:0] : rem_sh[18:0];
        dq_d  = {dq_q[34:0], div_ge};
        if (cnt_q == 7'd14) begin
          cnt_d   = '0;
          deg_we  = 1'b1;
          deg_val = {1'b0, dq_d[14:0]};
          term_d  = term_q + 4'd1;
        end
      end
      fpi_pkg::ST_RULE: begin
        if (cnt_q != 7'd0) begin
          w_d = wnext;
          if (rslot[2:0] == 3'd7) begin
            w_we   = 1'b1;
            w_val  = ({1'b0, rslot[5:3]} < 4'(fpi_pkg::OUTPUT_TERMS)) ? wnext : 16'd0;
            dacc_d = dacc_q + {3'd0, w_val};
          end
        end
        if (cnt_q == 7'd64) cnt_d = '0;
      end
      fpi_pkg::ST_ACC: begin
        pm_raddr = {4'b1000, cnt_q[2:0]};
        if (cnt_q >= 7'd1 && cnt_q <= 7'd8) begin
          prod_d = $signed(pm_rdata) * $signed({1'b0, warr_q[3'(cnt_q - 7'd1)]});
          pv_d   = 1'b1;
        end
        if (pv_q) num_d = num_q + 36'(prod_q);
        if (cnt_q == 7'd10) begin
          cnt_d = '0;
          fb_d  = (dacc_q == '0);
          neg_d = num_q[35];
          rem_d = '0;
          dq_d  = mag;
          den_d = dacc_q;
        end
      end
      fpi_pkg::ST_DIV_OUT: begin
        rem_d = div_ge ? rem_sub[18:0] : rem_sh[18:0];
        dq_d  = {dq_q[34:0], div_ge};
      end
      fpi_pkg::ST_DONE: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpi_pkg::ST_IDLE;
      term_q      <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      fb_q        <= 1'b0;
      rvld_q      <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      fb_q    <= fb_d;
      rv_q    <= rvld_q[rm_raddr];
      if (rm_we) rvld_q[in_i.entry_index] <= 1'b1;
      if (state_q == fpi_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    dacc_q <= dacc_d;
    num_q  <= num_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    if (state_q == fpi_pkg::ST_LOAD && cnt_q != 7'd0) begin
      pt_q[2'(cnt_q - 7'd1)] <= pm_rdata;
    end
    if (in_acc) begin
      xe_q <= in_i.error_sample;
      xr_q <= in_i.rate_sample;
    end
    if (deg_we) begin
      if (term_q[3]) rdeg_q[term_q[2:0]] <= deg_val;
      else edeg_q[term_q[2:0]] <= deg_val;
    end
    if (w_we) warr_q[w_idx] <= w_val;
    if (state_q == fpi_pkg::ST_DONE && out_free) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == fpi_pkg::ST_DONE))
    else $error("result word appeared outside the finish step");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpi_pkg::ST_DIV_DEG || state_q == fpi_pkg::ST_DIV_OUT) |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fpi_pkg::ST_DIV_OUT |-> den_q != '0)
    else $error("final divide started with zero strength sum");

  a_strength_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fpi_pkg::ST_ACC |-> dacc_q <= 19'd262144)
    else $error("strength sum out of range");
`endif

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  fpi_pkg::in_word_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  fpi_pkg::out_word_t out_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fuzzy_pd_inference DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the block's tables
  logic signed [15:0] err_pts [32];
  logic signed [15:0] rate_pts [32];
  logic signed [15:0] centers [8];
  logic [6:0] rules [64];
  logic signed [15:0] fallback;

  fpi_pkg::out_word_t drive_q[$];
  int errors = 0;
  int evals = 0;
  int fallbacks = 0;
  int cycles = 0;
  bit sat_hit = 0;

  function automatic longint membership(longint x, longint a, longint b,
                                        longint c, longint d);
    if (x < a || x > d) return 0;
    if (x == b && a == b) return 32768;
    if (x == d && c == d) return 32768;
    if (x >= b && x <= c) return 32768;
    if (x < b) return ((x - a) * 32768) / (b - a);
    if (x > c) return ((d - x) * 32768) / (d - c);
    return 0;
  endfunction

  function automatic fpi_pkg::out_word_t infer_drive(logic signed [15:0] xe,
                                                     logic signed [15:0] xr);
    longint ed [8];
    longint rd [8];
    longint num, den, w, m, de, dr, mag, q;
    fpi_pkg::out_word_t res;
    num = 0;
    den = 0;
    for (int i = 0; i < 8; i++) begin
      ed[i] = membership(xe, err_pts[4*i], err_pts[4*i+1], err_pts[4*i+2], err_pts[4*i+3]);
      rd[i] = membership(xr, rate_pts[4*i], rate_pts[4*i+1], rate_pts[4*i+2],
                         rate_pts[4*i+3]);
    end
    for (int i = 0; i < fpi_pkg::OUTPUT_TERMS; i++) begin
      w = 0;
      for (int j = 0; j < fpi_pkg::MAX_CONDITIONS; j++) begin
        if (rules[i*8+j][6]) begin
          de = ed[rules[i*8+j][5:3]];
          dr = rd[rules[i*8+j][2:0]];
          m = de < dr ? de : dr;
          if (m > w) w = m;
        end
      end
      num += longint'(centers[i]) * w;
      den += w;
    end
    if (den == 0) begin
      res.drive = fallback;
      res.no_rule_fired = 1'b1;
    end else begin
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      if (num < 0) q = -q;
      if (q > 32767 || q < -32768) sat_hit = 1;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      res.drive = q[15:0];
      res.no_rule_fired = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        report_mismatch("unexpected word", out_o.drive, 0);
      end else begin
        fpi_pkg::out_word_t exp_w;
        exp_w = drive_q.pop_front();
        if (out_o.drive !== exp_w.drive)
          report_mismatch("drive", out_o.drive, exp_w.drive);
        if (out_o.no_rule_fired !== exp_w.no_rule_fired)
          report_mismatch("no_rule_fired", out_o.no_rule_fired, exp_w.no_rule_fired);
      end
    end
  end

  // receiver stall pattern: phases of none, light and heavy
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_word(logic [2:0] kind, logic [5:0] idx, logic [15:0] val,
                           logic [15:0] xe, logic [15:0] xr);
    fpi_pkg::in_word_t w;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    w.kind = kind;
    w.entry_index = idx;
    w.entry_value = val;
    w.error_sample = xe;
    w.rate_sample = xr;
    in_i <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (kind)
      fpi_pkg::KIND_EVAL: begin
        drive_q.push_back(infer_drive(xe, xr));
        evals++;
        if (drive_q[$].no_rule_fired) fallbacks++;
      end
      fpi_pkg::KIND_ERR_PT: if (idx < 6'd32) err_pts[idx[4:0]] = val;
      fpi_pkg::KIND_RATE_PT: if (idx < 6'd32) rate_pts[idx[4:0]] = val;
      fpi_pkg::KIND_CENTER: if (idx < 6'd8) centers[idx[2:0]] = val;
      fpi_pkg::KIND_RULE: rules[idx] = val[6:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [15:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {{16{val[15]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fallback = val;
  endtask

  task automatic load_term(logic [2:0] kind, int term, int a, int b, int c, int d);
    send_word(kind, 6'(term*4), 16'(a), 16'h0, 16'h0);
    send_word(kind, 6'(term*4+1), 16'(b), 16'h0, 16'h0);
    send_word(kind, 6'(term*4+2), 16'(c), 16'h0, 16'h0);
    send_word(kind, 6'(term*4+3), 16'(d), 16'h0, 16'h0);
  endtask

  // random but sorted trapezoid, sometimes with shoulders
  task automatic random_term(logic [2:0] kind, int term);
    int p [4];
    int t;
    foreach (p[k]) p[k] = $urandom_range(0, 65535) - 32768;
    for (int x = 0; x < 4; x++)
      for (int y = 0; y < 3; y++)
        if (p[y] > p[y+1]) begin t = p[y]; p[y] = p[y+1]; p[y+1] = t; end
    if ($urandom_range(0, 3) == 0) p[0] = p[1];
    if ($urandom_range(0, 3) == 0) p[3] = p[2];
    load_term(kind, term, p[0], p[1], p[2], p[3]);
  endtask

  task automatic test_fill_tables();
    for (int t = 0; t < 8; t++) begin
      load_term(fpi_pkg::KIND_ERR_PT, t, -2048 + t*512, -1536 + t*512, -1280 + t*512,
                -768 + t*512);
      load_term(fpi_pkg::KIND_RATE_PT, t, -2048 + t*512, -2048 + t*512, -1024 + t*512,
                -512 + t*512);
      send_word(fpi_pkg::KIND_CENTER, 6'(t), 16'(-3000 + t*800), 16'h0, 16'h0);
    end
  endtask

  task automatic test_directed();
    // no rules yet: fallback path
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'h0000, 16'h0000);
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'h8000, 16'h7FFF);
    send_word(fpi_pkg::KIND_RULE, 6'd0, 16'h0040, 16'h0, 16'h0);     // err 0, rate 0
    send_word(fpi_pkg::KIND_RULE, 6'd9, 16'h007F, 16'h0, 16'h0);     // err 7, rate 7
    send_word(fpi_pkg::KIND_RULE, 6'd63, 16'hFFFF, 16'h0, 16'h0);
    // inside, slope, on shoulders, before a, past d
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'(-1400), 16'(-1500));
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'(-1800), 16'(-2048));
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'(-800), 16'(-600));
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'(-2100), 16'(-1500));
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'(-700), 16'(-1500));
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'(2600), 16'(3000));
    // c equal to d shoulder, at d
    load_term(fpi_pkg::KIND_ERR_PT, 7, 1000, 2000, 3000, 3000);
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'(3000), 16'(3000));
    // ignored kinds and out of range writes
    send_word(3'd5, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(3'd7, 6'h2A, 16'h5555, 16'hAAAA, 16'h5555);
    send_word(fpi_pkg::KIND_ERR_PT, 6'd40, 16'h7FFF, 16'h0, 16'h0);
    send_word(fpi_pkg::KIND_CENTER, 6'd12, 16'h8000, 16'h0, 16'h0);
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'(-1400), 16'(3000));
    drain();
  endtask

  task automatic test_saturation();
    send_word(fpi_pkg::KIND_CENTER, 6'd0, 16'h7FFF, 16'h0, 16'h0);
    send_word(fpi_pkg::KIND_CENTER, 6'd1, 16'h8000, 16'h0, 16'h0);
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'(-1400), 16'(-1500));
    send_word(fpi_pkg::KIND_RULE, 6'd8, 16'h0040, 16'h0, 16'h0);
    send_word(fpi_pkg::KIND_RULE, 6'd0, 16'h0000, 16'h0, 16'h0);
    send_word(fpi_pkg::KIND_EVAL, 6'd0, 16'h0, 16'(-1400), 16'(-1500));
    drain();
  endtask

  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_word(fpi_pkg::KIND_EVAL, 6'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
      end else if (r < 62) begin
        random_term(r[0] ? fpi_pkg::KIND_ERR_PT : fpi_pkg::KIND_RATE_PT,
                    $urandom_range(0, 7));
      end else if (r < 70) begin
        send_word(fpi_pkg::KIND_CENTER, 6'($urandom_range(0, 7)), 16'($urandom),
                  16'h0, 16'h0);
      end else if (r < 92) begin
        send_word(fpi_pkg::KIND_RULE, 6'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
      end else if (r < 96) begin
        // out-of-range table index, stays ignored
        send_word(3'($urandom_range(1, 3)), 6'($urandom_range(32, 63)),
                  16'($urandom), 16'h0, 16'h0);
      end else begin
        send_word(3'($urandom_range(5, 7)), 6'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    foreach (rules[k]) rules[k] = '0;
    foreach (err_pts[k]) err_pts[k] = '0;
    foreach (rate_pts[k]) rate_pts[k] = '0;
    foreach (centers[k]) centers[k] = '0;
    fallback = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_write(16'h1234);
    test_fill_tables();
    test_directed();
    test_saturation();
    apb_write(16'h7FFF);
    test_random(120);
    drain();
    apb_write(16'h8000);
    test_random(120);
    drain();
    apb_write(16'h0000);
    test_random(120);
    drain();
    repeat (500) @(posedge clk_i);
    $display("covered %0d evaluations, %0d on the fallback path, saturation %0s",
             evals, fallbacks, sat_hit ? "reached" : "not reached");
    $display("tables reloaded at random between evaluations, three fallback settings");
    if (errors == 0 && drive_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d words outstanding", errors, drive_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
